>>> src/bfs_pkg.sv
// Shared types, constants and helpers for the bounded FIFO with key search.
`timescale 1ns / 1ps

package bfs_pkg;

    localparam int DEPTH   = 16;
    localparam int WORD_W  = 32;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int LIMIT_W = 5;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        ACT_ENQ    = 2'd0,
        ACT_DEQ    = 2'd1,
        ACT_SEARCH = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SEARCH
    } t_state;

    typedef struct packed {
        logic              ok;
        logic [WORD_W-1:0] data;
        logic [CNT_W-1:0]  count;
        logic [WORD_W-1:0] front;
        logic [WORD_W-1:0] rear;
    } t_result;

    function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] slot);
        logic [ADDR_W-1:0] res;
        if (slot == ADDR_W'(DEPTH - 1)) begin
            res = '0;
        end else begin
            res = slot + 1'b1;
        end
        return res;
    endfunction

endpackage

>>> src/bfs_ram.sv
// Simple dual-port word store with one write port and a registered read port.
`timescale 1ns / 1ps

module bfs_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/bounded_fifo_with_search.sv
// Bounded FIFO with occupancy limit and key search; the words live in one synchronous RAM.
// Enqueue, clear, a search of the empty queue and a dequeue of at most one word load their
// result when they start; a dequeue that refills the front loads it after the RAM read.
// A search reads one stored word per cycle until every stored word has been read.
// The input register takes no new item until its result is loaded. Synchronous active-low
// reset empties the queue and clears the limit.
`timescale 1ns / 1ps

module bounded_fifo_with_search (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bfs_pkg::LIMIT_W-1:0] i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_action,
    input  logic [31:0]                 i_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_ok,
    output logic [31:0]                 o_data_out,
    output logic [bfs_pkg::COUNT_W-1:0] o_count_after,
    output logic [31:0]                 o_front_word,
    output logic [31:0]                 o_rear_word
);

    bfs_pkg::t_state  r_state;
    bfs_pkg::t_state  n_state;

    logic [bfs_pkg::ADDR_W-1:0]  r_head;
    logic [bfs_pkg::ADDR_W-1:0]  r_tail;
    logic [bfs_pkg::CNT_W-1:0]   r_count;
    logic [bfs_pkg::LIMIT_W-1:0] r_limit;

    logic                        r_pend;
    bfs_pkg::t_action            r_action;
    logic [bfs_pkg::WORD_W-1:0]  r_value;

    logic [bfs_pkg::WORD_W-1:0]  r_front;
    logic [bfs_pkg::WORD_W-1:0]  r_rear;
    logic [bfs_pkg::WORD_W-1:0]  r_deq;

    logic [bfs_pkg::ADDR_W-1:0]  r_slot;
    logic [bfs_pkg::CNT_W-1:0]   r_idx;
    logic                        r_chk;
    logic                        r_found;

    logic                        r_o_valid;
    bfs_pkg::t_result            r_o_res;

    logic [bfs_pkg::CNT_W-1:0]   w_lim;
    logic                        w_can_enq;
    logic                        w_out_free;
    logic                        w_start;
    logic                        w_issue;
    logic                        w_hit;
    logic                        w_search_done;
    logic                        w_load;
    bfs_pkg::t_result            w_res;
    bfs_pkg::t_result            w_raw;

    logic                        w_we;
    logic                        w_re;
    logic [bfs_pkg::ADDR_W-1:0]  w_raddr;
    logic [bfs_pkg::WORD_W-1:0]  w_rdata;

    bfs_ram #(
        .DEPTH  (bfs_pkg::DEPTH),
        .WIDTH  (bfs_pkg::WORD_W),
        .ADDR_W (bfs_pkg::ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_tail),
        .i_wdata (r_value),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // A limit of zero, or one above the store depth, means the whole store.
    assign w_lim = (r_limit == '0 || r_limit > bfs_pkg::LIMIT_W'(bfs_pkg::DEPTH))
                   ? bfs_pkg::CNT_W'(bfs_pkg::DEPTH)
                   : bfs_pkg::CNT_W'(r_limit);
    assign w_can_enq = (r_count < w_lim);

    assign w_out_free    = !r_o_valid || i_ready;
    assign w_start       = (r_state == bfs_pkg::ST_IDLE) && r_pend && w_out_free;
    assign w_issue       = (r_idx != r_count);
    assign w_hit         = r_chk && (w_rdata == r_value);
    assign w_search_done = !w_issue && !r_chk;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !r_pend;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bfs_pkg::ST_IDLE: begin
                if (w_start) begin
                    if (r_action == bfs_pkg::ACT_DEQ && r_count > bfs_pkg::CNT_W'(1)) begin
                        n_state = bfs_pkg::ST_FETCH;
                    end else if (r_action == bfs_pkg::ACT_SEARCH && r_count != '0) begin
                        n_state = bfs_pkg::ST_SEARCH;
                    end
                end
            end
            bfs_pkg::ST_FETCH: begin
                n_state = bfs_pkg::ST_IDLE;
            end
            bfs_pkg::ST_SEARCH: begin
                if (w_search_done) begin
                    n_state = bfs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bfs_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory controls and the result to load into the output register.
    always_comb begin
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_raddr = r_slot;
        w_load  = 1'b0;
        w_raw   = '0;
        unique case (r_state)
            bfs_pkg::ST_IDLE: begin
                if (w_start) begin
                    unique case (r_action)
                        bfs_pkg::ACT_ENQ: begin
                            w_we        = w_can_enq;
                            w_load      = 1'b1;
                            w_raw.ok    = w_can_enq;
                            w_raw.count = w_can_enq ? r_count + 1'b1 : r_count;
                            w_raw.front = (r_count == '0) ? r_value : r_front;
                            w_raw.rear  = w_can_enq ? r_value : r_rear;
                        end
                        bfs_pkg::ACT_DEQ: begin
                            // Fetch the new front word; the result waits for it.
                            w_re    = (r_count > bfs_pkg::CNT_W'(1));
                            w_raddr = bfs_pkg::next_slot(r_head);
                            w_load  = (r_count <= bfs_pkg::CNT_W'(1));
                            w_raw.ok    = (r_count != '0);
                            w_raw.data  = (r_count != '0) ? r_front : '0;
                            w_raw.count = '0;
                        end
                        bfs_pkg::ACT_SEARCH: begin
                            w_load      = (r_count == '0);
                            w_raw.count = '0;
                        end
                        bfs_pkg::ACT_CLEAR: begin
                            w_load      = 1'b1;
                            w_raw.ok    = 1'b1;
                            w_raw.count = '0;
                        end
                        default: begin
                            w_load = 1'b0;
                        end
                    endcase
                end
            end
            bfs_pkg::ST_FETCH: begin
                w_load      = 1'b1;
                w_raw.ok    = 1'b1;
                w_raw.data  = r_deq;
                w_raw.count = r_count;
                w_raw.front = w_rdata;
                w_raw.rear  = r_rear;
            end
            bfs_pkg::ST_SEARCH: begin
                w_re        = w_issue;
                w_raddr     = r_slot;
                w_load      = w_search_done;
                w_raw.ok    = r_found;
                w_raw.count = r_count;
                w_raw.front = r_front;
                w_raw.rear  = r_rear;
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
        w_res       = w_raw;
        w_res.front = (w_raw.count != '0) ? w_raw.front : '0;
        w_res.rear  = (w_raw.count != '0) ? w_raw.rear : '0;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bfs_pkg::ST_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_limit   <= '0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
            r_idx     <= '0;
            r_chk     <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (i_valid && o_ready) begin
                r_pend <= 1'b1;
            end else if (w_load) begin
                r_pend <= 1'b0;
            end
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (w_start) begin
                r_idx   <= '0;
                r_chk   <= 1'b0;
                r_found <= 1'b0;
                unique case (r_action)
                    bfs_pkg::ACT_ENQ: begin
                        if (w_can_enq) begin
                            r_tail  <= bfs_pkg::next_slot(r_tail);
                            r_count <= r_count + 1'b1;
                        end
                    end
                    bfs_pkg::ACT_DEQ: begin
                        if (r_count != '0) begin
                            r_head  <= bfs_pkg::next_slot(r_head);
                            r_count <= r_count - 1'b1;
                        end
                    end
                    bfs_pkg::ACT_SEARCH: begin
                        r_idx <= '0;
                    end
                    bfs_pkg::ACT_CLEAR: begin
                        r_head  <= '0;
                        r_tail  <= '0;
                        r_count <= '0;
                    end
                    default: begin
                        r_idx <= '0;
                    end
                endcase
            end else if (r_state == bfs_pkg::ST_SEARCH) begin
                // One read per cycle; each compare sees the word from the previous read.
                r_chk   <= w_issue;
                r_found <= r_found | w_hit;
                if (w_issue) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_action <= bfs_pkg::t_action'(i_action);
            r_value  <= i_value;
        end
        if (w_load) begin
            r_o_res <= w_res;
        end
        if (w_start) begin
            r_slot <= r_head;
            if (r_action == bfs_pkg::ACT_ENQ && w_can_enq) begin
                r_rear <= r_value;
                if (r_count == '0) begin
                    r_front <= r_value;
                end
            end
            if (r_action == bfs_pkg::ACT_DEQ) begin
                r_deq <= r_front;
            end
        end else if (r_state == bfs_pkg::ST_SEARCH) begin
            if (w_issue) begin
                r_slot <= bfs_pkg::next_slot(r_slot);
            end
        end else if (r_state == bfs_pkg::ST_FETCH) begin
            r_front <= w_rdata;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_ok          = r_o_res.ok;
    assign o_data_out    = r_o_res.data;
    assign o_count_after = bfs_pkg::COUNT_W'(r_o_res.count);
    assign o_front_word  = r_o_res.front;
    assign o_rear_word   = r_o_res.rear;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bfs_pkg::CNT_W'(bfs_pkg::DEPTH))
        else $error("entry count exceeds the store depth");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == r_tail) == (r_count == '0 || r_count == bfs_pkg::CNT_W'(bfs_pkg::DEPTH)))
        else $error("head and tail disagree with the entry count");

    a_fetch_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bfs_pkg::ST_FETCH) |-> !r_o_valid)
        else $error("front refill finishing while a result is still held");

    a_load_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> r_pend)
        else $error("result produced without a pending item");
`endif

endmodule

>>> tb/bounded_fifo_with_search_test.sv
// Self-checking testbench for the bounded FIFO with occupancy limit and key search.
`timescale 1ns / 1ps

module bounded_fifo_with_search_test;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic                        ok;
        logic [31:0]                 data;
        logic [bfs_pkg::COUNT_W-1:0] count;
        logic [31:0]                 front;
        logic [31:0]                 rear;
    } t_queue_reply;

    // Tracks the queue contents and the limit, and predicts the reply to every
    // accepted request.
    class t_queue_scoreboard;
        logic [31:0]                words [bfs_pkg::DEPTH];
        logic [bfs_pkg::ADDR_W-1:0] head;
        logic [bfs_pkg::ADDR_W-1:0] tail;
        int                         count;
        int                         limit;
        t_queue_reply               expected_replies [$];
        int                         errors;
        int                         replies_checked;
        int                         requests [4];
        int                         refused_enqueues;
        int                         search_hits;

        function new();
            head = '0;
            tail = '0;
            count = 0;
            limit = 0;
            errors = 0;
            replies_checked = 0;
            refused_enqueues = 0;
            search_hits = 0;
            foreach (requests[k]) requests[k] = 0;
        endfunction

        function void set_limit(logic [bfs_pkg::LIMIT_W-1:0] value);
            limit = int'(value);
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        // Word at the given position counted from the oldest entry.
        function logic [31:0] stored_word(int pos);
            return words[bfs_pkg::ADDR_W'((int'(head) + pos) % bfs_pkg::DEPTH)];
        endfunction

        function void note_request(bfs_pkg::t_action act, logic [31:0] value);
            t_queue_reply               reply;
            int                         cap;
            logic [bfs_pkg::ADDR_W-1:0] slot;
            logic [bfs_pkg::ADDR_W-1:0] rear_slot;
            reply = '0;
            cap = (limit == 0 || limit > bfs_pkg::DEPTH) ? bfs_pkg::DEPTH : limit;
            requests[act]++;
            case (act)
                bfs_pkg::ACT_ENQ: begin
                    if (count < cap) begin
                        words[tail] = value;
                        tail = bfs_pkg::next_slot(tail);
                        count++;
                        reply.ok = 1'b1;
                    end else begin
                        refused_enqueues++;
                    end
                end
                bfs_pkg::ACT_DEQ: begin
                    if (count != 0) begin
                        reply.data = words[head];
                        head = bfs_pkg::next_slot(head);
                        count--;
                        reply.ok = 1'b1;
                    end
                end
                bfs_pkg::ACT_SEARCH: begin
                    slot = head;
                    for (int i = 0; i < count; i++) begin
                        if (words[slot] == value) begin
                            reply.ok = 1'b1;
                            search_hits++;
                            break;
                        end
                        slot = bfs_pkg::next_slot(slot);
                    end
                end
                default: begin
                    head = '0;
                    tail = '0;
                    count = 0;
                    reply.ok = 1'b1;
                end
            endcase
            reply.count = bfs_pkg::COUNT_W'(count);
            if (count != 0) begin
                rear_slot = (tail == '0) ? bfs_pkg::ADDR_W'(bfs_pkg::DEPTH - 1) : tail - 1'b1;
                reply.front = words[head];
                reply.rear = words[rear_slot];
            end
            expected_replies.push_back(reply);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_reply(logic ok, logic [31:0] data,
                                  logic [bfs_pkg::COUNT_W-1:0] cnt,
                                  logic [31:0] front, logic [31:0] rear);
            t_queue_reply want;
            if (expected_replies.size() == 0) begin
                $error("result transfer with no request outstanding");
                errors++;
                return;
            end
            want = expected_replies.pop_front();
            replies_checked++;
            compare_field("ok", 32'(want.ok), 32'(ok));
            compare_field("data_out", want.data, data);
            compare_field("count_after", 32'(want.count), 32'(cnt));
            compare_field("front_word", want.front, front);
            compare_field("rear_word", want.rear, rear);
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [bfs_pkg::LIMIT_W-1:0]   i_cfg_data;
    logic                          i_valid;
    logic                          o_ready;
    logic [1:0]                    i_action;
    logic [31:0]                   i_value;
    logic                          o_valid;
    logic                          i_ready;
    logic                          o_ok;
    logic [31:0]                   o_data_out;
    logic [bfs_pkg::COUNT_W-1:0]   o_count_after;
    logic [31:0]                   o_front_word;
    logic [31:0]                   o_rear_word;

    t_queue_scoreboard sb;
    int                sender_idle_pct;
    int                receiver_idle_pct;
    int                stall_left;
    int                cycles;

    bounded_fifo_with_search dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_ok          (o_ok),
        .o_data_out    (o_data_out),
        .o_count_after (o_count_after),
        .o_front_word  (o_front_word),
        .o_rear_word   (o_rear_word)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // The receiver stalls at random, or for a whole stretch while stall_left runs down.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_reply(o_ok, o_data_out, o_count_after, o_front_word, o_rear_word);
        end
    end

    // Called just after a falling edge; returns just after a falling edge with
    // the transfer done and valid still high.
    task automatic send_request(bfs_pkg::t_action act, logic [31:0] value);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_value <= value;
        forever begin
            @(posedge i_clk);
            if (o_ready) break;
        end
        sb.note_request(act, value);
        @(negedge i_clk);
    endtask

    // Writes the limit once every outstanding reply has come back.
    task automatic write_limit(logic [bfs_pkg::LIMIT_W-1:0] value);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        sb.set_limit(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] random_word();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2, 3, 4: return 32'($urandom_range(7));
            default: return $urandom;
        endcase
    endfunction

    // enq_pct sets how hard the queue is pushed toward full; the rest is
    // mostly dequeues and searches, with a rare clear.
    task automatic run_random(int n_items, int enq_pct);
        int               pick;
        bfs_pkg::t_action act;
        logic [31:0]      value;
        repeat (n_items) begin
            pick = $urandom_range(99);
            value = random_word();
            if (pick < enq_pct) begin
                act = bfs_pkg::ACT_ENQ;
            end else if (pick < 75) begin
                act = bfs_pkg::ACT_DEQ;
            end else if (pick < 99) begin
                act = bfs_pkg::ACT_SEARCH;
                if (sb.count != 0 && $urandom_range(1)) begin
                    value = sb.stored_word($urandom_range(sb.count - 1));
                end
            end else begin
                act = bfs_pkg::ACT_CLEAR;
            end
            send_request(act, value);
        end
    endtask

    initial begin
        sb = new();
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_action = bfs_pkg::ACT_ENQ;
        i_value = '0;
        i_ready = 1'b0;
        stall_left = 0;
        cycles = 0;
        sender_idle_pct = 8;
        receiver_idle_pct = 53;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty-queue corners, both extreme words, hit and miss, clear.
        write_limit(5'd0);
        send_request(bfs_pkg::ACT_DEQ, 32'h0);
        send_request(bfs_pkg::ACT_SEARCH, 32'h0);
        send_request(bfs_pkg::ACT_ENQ, 32'h0000_0000);
        send_request(bfs_pkg::ACT_ENQ, 32'hFFFF_FFFF);
        send_request(bfs_pkg::ACT_ENQ, 32'hAAAA_AAAA);
        send_request(bfs_pkg::ACT_ENQ, 32'h5555_5555);
        send_request(bfs_pkg::ACT_SEARCH, 32'hFFFF_FFFF);
        send_request(bfs_pkg::ACT_SEARCH, 32'h1234_5678);
        send_request(bfs_pkg::ACT_DEQ, 32'h0);
        send_request(bfs_pkg::ACT_CLEAR, 32'h0);
        send_request(bfs_pkg::ACT_DEQ, 32'h0);

        // A small limit refuses the fourth enqueue.
        write_limit(5'd3);
        send_request(bfs_pkg::ACT_ENQ, 32'h1);
        send_request(bfs_pkg::ACT_ENQ, 32'h2);
        send_request(bfs_pkg::ACT_ENQ, 32'h3);
        send_request(bfs_pkg::ACT_ENQ, 32'h4);

        // Limit dropped below the count: full until the queue drains below it.
        write_limit(5'd1);
        send_request(bfs_pkg::ACT_ENQ, 32'h5);
        send_request(bfs_pkg::ACT_SEARCH, 32'h3);
        send_request(bfs_pkg::ACT_DEQ, 32'h0);
        send_request(bfs_pkg::ACT_DEQ, 32'h0);
        send_request(bfs_pkg::ACT_ENQ, 32'h6);
        send_request(bfs_pkg::ACT_DEQ, 32'h0);
        send_request(bfs_pkg::ACT_ENQ, 32'h7);
        send_request(bfs_pkg::ACT_DEQ, 32'h0);

        write_limit(5'd16);
        run_random(100, 55);
        write_limit(5'd0);
        // Long receiver hold-off so the block backs up and stalls its input.
        stall_left = 80;
        run_random(100, 35);

        sender_idle_pct = 53;
        receiver_idle_pct = 8;
        write_limit(5'd31);
        run_random(100, 55);
        write_limit(5'd2);
        run_random(100, 35);

        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        write_limit(5'd12);
        run_random(100, 55);
        write_limit(5'd0);
        run_random(100, 40);
        i_valid <= 1'b0;

        while (sb.pending() != 0) @(negedge i_clk);
        repeat (bfs_pkg::DEPTH + 8) @(negedge i_clk);

        $display("Checked %0d replies: %0d enqueue, %0d dequeue, %0d search, %0d clear.",
                 sb.replies_checked, sb.requests[bfs_pkg::ACT_ENQ],
                 sb.requests[bfs_pkg::ACT_DEQ], sb.requests[bfs_pkg::ACT_SEARCH],
                 sb.requests[bfs_pkg::ACT_CLEAR]);
        $display("Refused enqueues %0d, search hits %0d, limits from 0 to 31 exercised.",
                 sb.refused_enqueues, sb.search_hits);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
